>>> rtl/rlim_pkg.sv
`timescale 1ns / 1ps

package rlim_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int KEY_W         = 32;
    localparam int TIME_W        = 32;
    localparam int CNT_W         = 8;
    localparam int ENTRY_W       = KEY_W + CNT_W + TIME_W;
    localparam int PADDR_W       = 3;

    localparam logic [CNT_W-1:0] MAX_PER_WINDOW_RESET = 8'd10;
    localparam logic [CNT_W-1:0] COUNT_ONE            = 8'd1;

    // register index 0 sits at byte address 0, decoded on the word bit
    localparam logic REG_MAX_PER_WINDOW = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic write;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_over;
        logic rem_done;
    } dp_status_t;

endpackage

>>> rtl/rlim_ctrl.sv
`timescale 1ns / 1ps

module rlim_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rlim_pkg::dp_status_t status,
    output rlim_pkg::dp_cmd_t    cmd
);
    import rlim_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_over && status.rem_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                // hold the update until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.write      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/rlim_dp.sv
`timescale 1ns / 1ps

module rlim_dp #(
    parameter int TABLE_DEPTH = rlim_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rlim_pkg::dp_cmd_t             cmd,
    output rlim_pkg::dp_status_t          status,
    input  logic [rlim_pkg::KEY_W-1:0]    client_ip,
    input  logic [rlim_pkg::TIME_W-1:0]   now_seconds,
    input  logic [rlim_pkg::CNT_W-1:0]    max_per_window,
    output logic                          allowed
);
    import rlim_pkg::*;

    localparam int ABITS   = $clog2(TABLE_DEPTH);
    localparam int UW      = $clog2(TABLE_DEPTH + 1);
    localparam int PROD_W  = 2 * TIME_W + 1;
    localparam int RECIP_W = TIME_W + 1;
    localparam int RSH     = TIME_W + ABITS;

    // reciprocal of the depth rounded up, exact quotient for every time value
    localparam longint unsigned RECIP_NUM = 64'd1 << RSH;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((RECIP_NUM + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));
    localparam logic [TIME_W-1:0] RECIP_LO = RECIP[TIME_W-1:0];
    localparam logic              RECIP_HI = RECIP[TIME_W];
    localparam logic [TIME_W-1:0] DEPTH_T  = TIME_W'(TABLE_DEPTH);

    localparam logic [UW-1:0]  DEPTH_U   = UW'(TABLE_DEPTH);

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    logic [KEY_W-1:0]  addr_reg;
    logic [TIME_W-1:0] now_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ABITS-1:0]  rem_reg;
    logic              rem_done_reg;
    logic [UW-1:0]     used_reg;
    logic [UW-1:0]     rd_idx_reg;
    logic              cmp_valid_reg;
    logic [ABITS-1:0]  cmp_idx_reg;
    logic              found_reg;
    logic [ABITS-1:0]  hit_idx_reg;
    logic [CNT_W-1:0]  hit_count_reg;
    logic [TIME_W-1:0] hit_window_reg;
    logic              allowed_reg;

    logic [KEY_W-1:0]    rd_key;
    logic                issue;
    logic                hit;
    logic [2*TIME_W-1:0] prod_lo;
    logic [PROD_W-1:0]   prod_full;
    logic [TIME_W-1:0]   quot;
    logic [TIME_W-1:0]   rem_full;
    logic                decide_write;
    logic                allow_val;
    logic                used_inc;
    logic [ABITS-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wdata;

    assign rd_key   = rdata_reg[ENTRY_W-1 -: KEY_W];
    assign issue    = cmd.scan && !found_reg && (rd_idx_reg < used_reg);
    assign hit      = cmd.scan && !found_reg && cmp_valid_reg && (rd_key == addr_reg);

    // time mod depth: product at the request transfer, remainder on the first scan cycle
    assign prod_lo   = {{TIME_W{1'b0}}, now_seconds} * {{TIME_W{1'b0}}, RECIP_LO};
    assign prod_full = {1'b0, prod_lo}
                     + (RECIP_HI ? {1'b0, now_seconds, {TIME_W{1'b0}}} : {PROD_W{1'b0}});
    assign quot      = TIME_W'(prod_reg >> RSH);
    assign rem_full  = now_reg - quot * DEPTH_T;

    assign status.scan_over = found_reg || ((rd_idx_reg == used_reg) && !cmp_valid_reg);
    assign status.rem_done  = rem_done_reg;
    assign allowed          = allowed_reg;

    always_comb
    begin
        decide_write = 1'b1;
        allow_val    = 1'b1;
        used_inc     = 1'b0;
        wr_addr      = hit_idx_reg;
        wdata        = {addr_reg, COUNT_ONE, now_reg};
        if (found_reg)
        begin
            priority if (now_reg != hit_window_reg)
            begin
                wdata = {addr_reg, COUNT_ONE, now_reg};
            end
            else if (hit_count_reg >= max_per_window)
            begin
                decide_write = 1'b0;
                allow_val    = 1'b0;
            end
            else
            begin
                wdata = {addr_reg, hit_count_reg + COUNT_ONE, hit_window_reg};
            end
        end
        else if (used_reg < DEPTH_U)
        begin
            wr_addr  = used_reg[ABITS-1:0];
            used_inc = 1'b1;
        end
        else
        begin
            // full table: evict entry at time mod depth
            wr_addr = rem_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rdata_reg <= mem[rd_idx_reg[ABITS-1:0]];
        end
        if (cmd.write && decide_write)
        begin
            mem[wr_addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            addr_reg <= client_ip;
            now_reg  <= now_seconds;
            prod_reg <= prod_full;
        end
        if (cmd.scan)
        begin
            rem_reg <= rem_full[ABITS-1:0];
        end
        if (issue)
        begin
            cmp_idx_reg <= rd_idx_reg[ABITS-1:0];
        end
        if (hit)
        begin
            hit_idx_reg    <= cmp_idx_reg;
            hit_count_reg  <= rdata_reg[TIME_W +: CNT_W];
            hit_window_reg <= rdata_reg[TIME_W-1:0];
        end
        if (cmd.write)
        begin
            allowed_reg <= allow_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            rem_done_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                rd_idx_reg    <= '0;
                cmp_valid_reg <= 1'b0;
                found_reg     <= 1'b0;
                rem_done_reg  <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (!found_reg)
                begin
                    cmp_valid_reg <= issue;
                    if (issue)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                end
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
                rem_done_reg <= 1'b1;
            end
            if (cmd.write && used_inc)
            begin
                used_reg <= used_reg + 1'b1;
            end
        end
    end

endmodule

>>> rtl/per_client_rate_limiter.sv
`timescale 1ns / 1ps

// Per-client fixed-window rate limiter. Each request transfer carries a client
// address and the current second; one result transfer with allowed comes back
// per request. A request scans the filled table entries one per cycle through a
// single registered memory read port, while the eviction slot (time mod
// TABLE_DEPTH) comes from a reciprocal multiply, its product registered at the
// request transfer and its remainder on the first scan cycle. The scan ends
// at the first matching entry, or after the last filled entry on a miss. The
// next request can be taken from the cycle in which the result is posted, so
// it may arrive before that result is taken. A result that is not taken holds
// back the table update of the next request. Table contents need no clearing
// after reset, only filled entries are ever searched.
// max_per_window sits at byte address 0 of the APB port, reset value 10.

module per_client_rate_limiter #(
    parameter int TABLE_DEPTH = rlim_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rlim_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rlim_pkg::KEY_W-1:0]    client_ip,
    input  logic [rlim_pkg::TIME_W-1:0]   now_seconds,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          allowed
);
    import rlim_pkg::*;

    logic [CNT_W-1:0] max_reg;
    logic             reg_sel;
    dp_cmd_t          cmd;
    dp_status_t       status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1] == REG_MAX_PER_WINDOW);
    assign prdata  = reg_sel ? {{(32 - CNT_W){1'b0}}, max_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_PER_WINDOW_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            max_reg <= pwdata[CNT_W-1:0];
        end
    end

    rlim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rlim_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .client_ip      (client_ip),
        .now_seconds    (now_seconds),
        .max_per_window (max_reg),
        .allowed        (allowed)
    );

endmodule
